/* sv/hpc_pkg.sv */
// Shared types and constants of the homogeneous primitive clipper.
package hpc_pkg;

  localparam int NUM_COMP   = 10;
  localparam int NUM_PLANES = 7;
  localparam int COL_WIDTH  = 16;
  localparam int TEX_WIDTH  = 32;

  // Component slots of one stored vertex record.
  localparam int COMP_X = 0;
  localparam int COMP_Y = 1;
  localparam int COMP_Z = 2;
  localparam int COMP_W = 3;
  localparam int COMP_R = 4;
  localparam int COMP_G = 5;
  localparam int COMP_B = 6;
  localparam int COMP_A = 7;
  localparam int COMP_U = 8;
  localparam int COMP_V = 9;

  // Clip planes in the order they are applied.
  localparam logic [2:0] PLANE_W  = 3'd0;
  localparam logic [2:0] PLANE_XN = 3'd1;
  localparam logic [2:0] PLANE_XP = 3'd2;
  localparam logic [2:0] PLANE_YN = 3'd3;
  localparam logic [2:0] PLANE_YP = 3'd4;
  localparam logic [2:0] PLANE_ZN = 3'd5;
  localparam logic [2:0] PLANE_ZP = 3'd6;

  localparam logic [1:0] NEED_TRI  = 2'd3;
  localparam logic [1:0] NEED_LINE = 2'd2;

  // Output actions of one polygon edge.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_COPY_A  = 3'd1,
    OP_COPY_C  = 3'd2,
    OP_ISECT_A = 3'd3,  // inside vertex is the edge start
    OP_ISECT_C = 3'd4   // inside vertex is the edge end
  } op_e;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_PSTART = 12'b000000000010,
    S_FIRST  = 12'b000000000100,
    S_RDC    = 12'b000000001000,
    S_WAITC  = 12'b000000010000,
    S_OP     = 12'b000000100000,
    S_DIV    = 12'b000001000000,
    S_MUL    = 12'b000010000000,
    S_ADD    = 12'b000100000000,
    S_ESTART = 12'b001000000000,
    S_ERD    = 12'b010000000000,
    S_ELD    = 12'b100000000000
  } state_e;

endpackage

/* sv/hpc_vert_mem.sv */
// Vertex record memory: one write port, one registered read port.
module hpc_vert_mem #(
  parameter int DEPTH = 20,
  parameter int AW    = 5,
  parameter int W     = 320
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/hpc_div.sv */
// Bit-serial restoring divider that forms the rounded intersection weight.
module hpc_div #(
  parameter int DW = 34,
  parameter int F  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [F:0]    t_o
);

  localparam int CNTW = $clog2(F + 1);
  localparam logic [CNTW-1:0] LAST = CNTW'(F);
  localparam logic [F+1:0] ONE = {2'b01, {F{1'b0}}};

  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic [F:0]      t_q, t_d;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic            ge;
  logic [DW:0]     diffr;
  logic [F+1:0]    tr;

  assign ge    = rem_q >= {1'b0, den_q};
  assign diffr = ge ? rem_q - {1'b0, den_q} : rem_q;
  assign rem_d = {diffr[DW-1:0], 1'b0};
  assign t_d   = {t_q[F-1:0], ge};

  // After the last quotient bit the shifted remainder gives the round bit.
  assign tr  = {1'b0, t_q} + {{(F+1){1'b0}}, ge};
  assign t_o = (tr > ONE) ? ONE[F:0] : tr[F:0];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      t_q   <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      t_q   <= t_d;
    end
  end

endmodule

/* sv/hpc_mix.sv */
// One-component interpolator: registered multiply, then round and add.
module hpc_mix #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] o_i,
  input  logic [CW-1:0] i_i,
  input  logic [F:0]    t_i,
  output logic [CW-1:0] res_o
);

  localparam int PW = CW + F + 2;
  localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);

  logic signed [CW:0] diff;
  logic [CW:0]        mag;
  logic [PW-1:0]      prod_q;
  logic               neg_q;
  logic [CW-1:0]      o_q;
  logic [PW:0]        rnd;
  logic [CW:0]        r;
  logic [CW:0]        sum;

  assign diff = signed'({i_i[CW-1], i_i}) - signed'({o_i[CW-1], o_i});
  assign mag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(mag) * PW'(t_i);
      neg_q  <= diff[CW];
      o_q    <= o_i;
    end
  end

  assign rnd   = ({1'b0, prod_q} + HALF) >> F;
  assign r     = rnd[CW:0];
  assign sum   = neg_q ? {o_q[CW-1], o_q} - r : {o_q[CW-1], o_q} + r;
  assign res_o = sum[CW-1:0];

endmodule

/* sv/homogeneous_primitive_clipper_top.sv */
// Homogeneous primitive clipper: groups vertices into triangles or lines and clips them.
// A vertex that does not complete a primitive is taken without holding off the input. A
// vertex that completes one holds the input off while a sequencer walks seven plane passes
// over a polygon memory of 2*MAX_POLY_VERTS records. Each intersection runs the bit-serial
// weight divider, and then one shared multiplier interpolates the ten components. Each
// emitted vertex is then read through the single memory read port when the output is not
// stalled.
module homogeneous_primitive_clipper_top #(
  parameter int MAX_POLY_VERTS   = 10,
  parameter int POS_WIDTH        = 32,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic signed [POS_WIDTH-1:0] pos_w_i,
  input  logic [15:0]                 col_r_i,
  input  logic [15:0]                 col_g_i,
  input  logic [15:0]                 col_b_i,
  input  logic [15:0]                 col_a_i,
  input  logic signed [31:0]          tex_u_i,
  input  logic signed [31:0]          tex_v_i,
  input  logic                        batch_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [POS_WIDTH-1:0] out_x_o,
  output logic signed [POS_WIDTH-1:0] out_y_o,
  output logic signed [POS_WIDTH-1:0] out_z_o,
  output logic signed [POS_WIDTH-1:0] out_w_o,
  output logic [15:0]                 out_r_o,
  output logic [15:0]                 out_g_o,
  output logic [15:0]                 out_b_o,
  output logic [15:0]                 out_a_o,
  output logic signed [31:0]          out_u_o,
  output logic signed [31:0]          out_v_o,
  output logic                        last_of_run_o
);

  localparam int CW    = (POS_WIDTH > 32) ? POS_WIDTH : 32;
  localparam int DEPTH = 2 * MAX_POLY_VERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_POLY_VERTS + 1);
  localparam int F     = WEIGHT_FRAC_BITS;
  localparam int DSW   = CW + 2;
  localparam int NC    = hpc_pkg::NUM_COMP;
  localparam logic [IW-1:0] MAXV      = IW'(MAX_POLY_VERTS);
  localparam logic [AW-1:0] BUF1_BASE = AW'(MAX_POLY_VERTS);
  localparam logic [3:0]    LAST_COMP = 4'(NC - 1);
  localparam logic [2:0]    LAST_PLANE = 3'(hpc_pkg::NUM_PLANES - 1);

  typedef logic [NC-1:0][CW-1:0] vert_t;

  function automatic logic [AW-1:0] vaddr(logic b, logic [IW-1:0] idx);
    logic [AW-1:0] a;
    a = AW'(idx);
    return b ? BUF1_BASE + a : a;
  endfunction

  function automatic logic signed [DSW-1:0] plane_dist(vert_t v, logic [2:0] p);
    logic signed [DSW-1:0] x, y, z, w, d;
    x = DSW'(signed'(v[hpc_pkg::COMP_X]));
    y = DSW'(signed'(v[hpc_pkg::COMP_Y]));
    z = DSW'(signed'(v[hpc_pkg::COMP_Z]));
    w = DSW'(signed'(v[hpc_pkg::COMP_W]));
    case (p)
      hpc_pkg::PLANE_W:  d = w;
      hpc_pkg::PLANE_XN: d = w - x;
      hpc_pkg::PLANE_XP: d = w + x;
      hpc_pkg::PLANE_YN: d = w - y;
      hpc_pkg::PLANE_YP: d = w + y;
      hpc_pkg::PLANE_ZN: d = w - z;
      hpc_pkg::PLANE_ZP: d = w + z;
      default:           d = w;
    endcase
    return d;
  endfunction

  hpc_pkg::state_e state_q, state_d;
  logic          draw_mode_q;
  logic [1:0]    vc_q, vc_d;
  logic          buf_q, buf_d;
  logic [IW-1:0] n_q, n_d, m_q, m_d, i_q, i_d, k_q, k_d;
  logic [2:0]    plane_q, plane_d;
  logic [1:0]    ph_q, ph_d, j_q, j_d;
  logic [3:0]    comp_q, comp_d;
  logic          in_is_a_q, in_is_a_d;
  logic          out_valid_q, out_valid_d;

  vert_t         a_q, a_d, c_q, c_d, first_q, first_d, res_q, res_d, out_q, out_d;
  logic [F:0]    tw_q, tw_d;
  logic          last_q, last_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  vert_t         mem_wdata, mem_rdata;

  logic          line;
  logic [1:0]    need, vc_base, vc_inc;
  logic          in_acc;
  vert_t         in_rec;
  logic [IW-1:0] edges, i_next;
  logic signed [DSW-1:0] da, dc, d_in, d_out;
  logic          ai, ci;
  hpc_pkg::op_e  ops [4];
  hpc_pkg::op_e  cur_op;
  logic          div_start, div_done;
  logic [DSW-1:0] div_num, div_den;
  logic [F:0]    div_t;
  logic          mix_en;
  logic [CW-1:0] mix_o, mix_i, mix_res;
  vert_t         in_v, out_v;
  logic [IW-1:0] eidx;
  logic          emit_ok;

  assign line        = draw_mode_q;
  assign need        = line ? hpc_pkg::NEED_LINE : hpc_pkg::NEED_TRI;
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != hpc_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  // A mode change can leave more vertices collected than the new mode needs.
  assign vc_base     = (vc_q >= need) ? 2'd0 : vc_q;
  assign vc_inc      = vc_base + 2'd1;

  always_comb begin
    in_rec = '0;
    in_rec[hpc_pkg::COMP_X] = CW'(pos_x_i);
    in_rec[hpc_pkg::COMP_Y] = CW'(pos_y_i);
    in_rec[hpc_pkg::COMP_Z] = CW'(pos_z_i);
    in_rec[hpc_pkg::COMP_W] = CW'(pos_w_i);
    in_rec[hpc_pkg::COMP_R] = CW'(col_r_i);
    in_rec[hpc_pkg::COMP_G] = CW'(col_g_i);
    in_rec[hpc_pkg::COMP_B] = CW'(col_b_i);
    in_rec[hpc_pkg::COMP_A] = CW'(col_a_i);
    in_rec[hpc_pkg::COMP_U] = CW'(tex_u_i);
    in_rec[hpc_pkg::COMP_V] = CW'(tex_v_i);
  end

  assign edges  = line ? ((n_q >= IW'(2)) ? IW'(1) : '0) : n_q;
  assign i_next = i_q + 1'b1;
  assign da     = plane_dist(a_q, plane_q);
  assign dc     = plane_dist(c_q, plane_q);
  assign ai     = !da[DSW-1];
  assign ci     = !dc[DSW-1];

  always_comb begin
    ops[0] = hpc_pkg::OP_NONE;
    ops[1] = hpc_pkg::OP_NONE;
    ops[2] = hpc_pkg::OP_NONE;
    ops[3] = hpc_pkg::OP_NONE;
    if (ai) begin
      if (line) begin
        ops[0] = hpc_pkg::OP_COPY_A;
        ops[1] = ci ? hpc_pkg::OP_COPY_C : hpc_pkg::OP_ISECT_A;
      end else begin
        ops[0] = ci ? hpc_pkg::OP_COPY_C : hpc_pkg::OP_ISECT_A;
      end
    end else if (ci) begin
      ops[0] = hpc_pkg::OP_ISECT_C;
      ops[1] = hpc_pkg::OP_COPY_C;
    end
  end
  assign cur_op = ops[ph_q];

  assign d_in    = (cur_op == hpc_pkg::OP_ISECT_A) ? da : dc;
  assign d_out   = (cur_op == hpc_pkg::OP_ISECT_A) ? dc : da;
  assign div_num = DSW'(-d_out);
  assign div_den = div_num + DSW'(d_in);

  assign in_v  = in_is_a_q ? a_q : c_q;
  assign out_v = in_is_a_q ? c_q : a_q;
  assign mix_i = in_v[comp_q];
  assign mix_o = out_v[comp_q];

  assign eidx    = line ? IW'(j_q) : ((j_q == 2'd0) ? '0 : k_q + IW'(j_q) - IW'(1));
  assign emit_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    vc_d        = vc_q;
    buf_d       = buf_q;
    n_d         = n_q;
    m_d         = m_q;
    i_d         = i_q;
    k_d         = k_q;
    plane_d     = plane_q;
    ph_d        = ph_q;
    j_d         = j_q;
    comp_d      = comp_q;
    in_is_a_d   = in_is_a_q;
    out_valid_d = out_valid_q && out_stall_i;
    a_d         = a_q;
    c_d         = c_q;
    first_d     = first_q;
    res_d       = res_q;
    out_d       = out_q;
    tw_d        = tw_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = in_rec;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    div_start   = 1'b0;
    mix_en      = 1'b0;

    case (state_q)
      hpc_pkg::S_IDLE: begin
        if (in_acc) begin
          mem_we    = 1'b1;
          mem_waddr = vaddr(1'b0, IW'(vc_base));
          vc_d      = (vc_inc == need || batch_end_i) ? 2'd0 : vc_inc;
          if (vc_inc == need) begin
            state_d = hpc_pkg::S_PSTART;
            buf_d   = 1'b0;
            n_d     = IW'(need);
            plane_d = hpc_pkg::PLANE_W;
          end
        end
      end
      hpc_pkg::S_PSTART: begin
        m_d = '0;
        i_d = '0;
        if (edges == '0) begin
          n_d   = '0;
          buf_d = !buf_q;
          if (plane_q == LAST_PLANE) begin
            state_d = hpc_pkg::S_ESTART;
          end else begin
            plane_d = plane_q + 3'd1;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = vaddr(buf_q, '0);
          state_d   = hpc_pkg::S_FIRST;
        end
      end
      hpc_pkg::S_FIRST: begin
        first_d = mem_rdata;
        a_d     = mem_rdata;
        state_d = hpc_pkg::S_RDC;
      end
      hpc_pkg::S_RDC: begin
        ph_d = 2'd0;
        if (i_next == n_q) begin
          // The closing edge of a polygon wraps to its first vertex.
          c_d     = first_q;
          state_d = hpc_pkg::S_OP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = vaddr(buf_q, i_next);
          state_d   = hpc_pkg::S_WAITC;
        end
      end
      hpc_pkg::S_WAITC: begin
        c_d     = mem_rdata;
        state_d = hpc_pkg::S_OP;
      end
      hpc_pkg::S_OP: begin
        if (cur_op == hpc_pkg::OP_NONE) begin
          a_d = c_q;
          i_d = i_next;
          if (i_next == edges) begin
            n_d   = m_q;
            buf_d = !buf_q;
            if (plane_q == LAST_PLANE) begin
              state_d = hpc_pkg::S_ESTART;
            end else begin
              plane_d = plane_q + 3'd1;
              state_d = hpc_pkg::S_PSTART;
            end
          end else begin
            state_d = hpc_pkg::S_RDC;
          end
        end else if (m_q == MAXV) begin
          // The polygon is full: further vertices of this pass are dropped.
          ph_d = ph_q + 2'd1;
        end else if (cur_op == hpc_pkg::OP_COPY_A || cur_op == hpc_pkg::OP_COPY_C) begin
          mem_we    = 1'b1;
          mem_waddr = vaddr(!buf_q, m_q);
          mem_wdata = (cur_op == hpc_pkg::OP_COPY_A) ? a_q : c_q;
          m_d       = m_q + 1'b1;
          ph_d      = ph_q + 2'd1;
        end else begin
          div_start = 1'b1;
          in_is_a_d = (cur_op == hpc_pkg::OP_ISECT_A);
          state_d   = hpc_pkg::S_DIV;
        end
      end
      hpc_pkg::S_DIV: begin
        if (div_done) begin
          tw_d    = div_t;
          comp_d  = '0;
          state_d = hpc_pkg::S_MUL;
        end
      end
      hpc_pkg::S_MUL: begin
        mix_en  = 1'b1;
        state_d = hpc_pkg::S_ADD;
      end
      hpc_pkg::S_ADD: begin
        res_d[comp_q] = mix_res;
        if (comp_q == LAST_COMP) begin
          mem_we    = 1'b1;
          mem_waddr = vaddr(!buf_q, m_q);
          mem_wdata = res_d;
          m_d       = m_q + 1'b1;
          ph_d      = ph_q + 2'd1;
          state_d   = hpc_pkg::S_OP;
        end else begin
          comp_d  = comp_q + 4'd1;
          state_d = hpc_pkg::S_MUL;
        end
      end
      hpc_pkg::S_ESTART: begin
        k_d = IW'(1);
        j_d = 2'd0;
        if (line ? (n_q >= IW'(2)) : (n_q >= IW'(3))) begin
          state_d = hpc_pkg::S_ERD;
        end else begin
          state_d = hpc_pkg::S_IDLE;
        end
      end
      hpc_pkg::S_ERD: begin
        if (emit_ok) begin
          mem_re    = 1'b1;
          mem_raddr = vaddr(buf_q, eidx);
          state_d   = hpc_pkg::S_ELD;
        end
      end
      hpc_pkg::S_ELD: begin
        out_d       = mem_rdata;
        out_valid_d = 1'b1;
        state_d     = hpc_pkg::S_ERD;
        if (line) begin
          last_d = (j_q == 2'd1);
          if (j_q == 2'd1) begin
            state_d = hpc_pkg::S_IDLE;
          end else begin
            j_d = j_q + 2'd1;
          end
        end else begin
          last_d = (j_q == 2'd2) && (k_q + IW'(2) == n_q);
          if (j_q == 2'd2) begin
            j_d = 2'd0;
            if (k_q + IW'(2) == n_q) begin
              state_d = hpc_pkg::S_IDLE;
            end else begin
              k_d = k_q + 1'b1;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = hpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hpc_pkg::S_IDLE;
      draw_mode_q <= 1'b0;
      vc_q        <= '0;
      buf_q       <= 1'b0;
      n_q         <= '0;
      m_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      plane_q     <= '0;
      ph_q        <= '0;
      j_q         <= '0;
      comp_q      <= '0;
      in_is_a_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        draw_mode_q <= cfg_data_i;
      end
      vc_q        <= vc_d;
      buf_q       <= buf_d;
      n_q         <= n_d;
      m_q         <= m_d;
      i_q         <= i_d;
      k_q         <= k_d;
      plane_q     <= plane_d;
      ph_q        <= ph_d;
      j_q         <= j_d;
      comp_q      <= comp_d;
      in_is_a_q   <= in_is_a_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    c_q     <= c_d;
    first_q <= first_d;
    res_q   <= res_d;
    out_q   <= out_d;
    tw_q    <= tw_d;
    last_q  <= last_d;
  end

  hpc_vert_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     ($bits(vert_t))
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hpc_div #(
    .DW (DSW),
    .F  (F)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .t_o     (div_t)
  );

  hpc_mix #(
    .CW (CW),
    .F  (F)
  ) u_mix (
    .clk_i (clk_i),
    .en_i  (mix_en),
    .o_i   (mix_o),
    .i_i   (mix_i),
    .t_i   (tw_q),
    .res_o (mix_res)
  );

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_q[hpc_pkg::COMP_X][POS_WIDTH-1:0];
  assign out_y_o       = out_q[hpc_pkg::COMP_Y][POS_WIDTH-1:0];
  assign out_z_o       = out_q[hpc_pkg::COMP_Z][POS_WIDTH-1:0];
  assign out_w_o       = out_q[hpc_pkg::COMP_W][POS_WIDTH-1:0];
  assign out_r_o       = out_q[hpc_pkg::COMP_R][15:0];
  assign out_g_o       = out_q[hpc_pkg::COMP_G][15:0];
  assign out_b_o       = out_q[hpc_pkg::COMP_B][15:0];
  assign out_a_o       = out_q[hpc_pkg::COMP_A][15:0];
  assign out_u_o       = out_q[hpc_pkg::COMP_U][31:0];
  assign out_v_o       = out_q[hpc_pkg::COMP_V][31:0];
  assign last_of_run_o = last_q;

endmodule
